/* design/lkv_pkg.sv */
// Package for the LRU key/value cache: command codes, controller states,
// configuration width and default sizes. No dependencies.
package lkv_pkg;

    localparam int CMD_W            = 2;
    localparam int CAP_W            = 6;
    localparam int DEF_ENTRIES      = 32;
    localparam int DEF_KEY_BITS     = 64;
    localparam int DEF_VALUE_BITS   = 32;
    localparam logic [CAP_W-1:0] CAP_RESET = 6'd33;

    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PROBE  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_UPDATE,
        ST_FINISH
    } lkv_state_t;

endpackage

/* design/lkv_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
module lkv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/lru_key_value_cache.sv */
// LRU key/value cache.
// Uses lkv_pkg and one lkv_ram instance that holds key, value and rank.
//
// Usage: each transaction on the s_* channel carries one command in s_tuser
// (lookup, insert or probe) with a key and a value in s_tdata. Each command
// yields exactly one result transaction on m_* with hit, found value, evicted
// flag and evicted value. The user must write the capacity register with
// cfg_we and cfg_data only while the block is idle; the block does not enforce it.
// Sequence: a command first sweeps every entry of the RAM to find the key,
// the least recent entry and the first free slot. Lookups that hit and
// inserts, unless the new entry is evicted at once, then sweep again to
// rewrite the recency ranks. The next command can be accepted in the cycle
// in which the result is issued. The RAM read port reads one entry per
// cycle. Commands are worked on one at a time.
// The result sits in an output register; while it waits for m_tready the
// next command is accepted and worked on, and it stalls only at its own end.
// Reset empties the cache (valid bits and occupancy clear at once) and sets
// the capacity to 33; no clearing pass is needed.
module lru_key_value_cache
    import lkv_pkg::*;
#(
    parameter int ENTRIES    = DEF_ENTRIES,
    parameter int KEY_BITS   = DEF_KEY_BITS,
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    localparam int IN_W  = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((2 * VALUE_BITS + 2 + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // key, entry_value
    input  logic [CMD_W-1:0] s_tuser,   // command
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // hit, found_value, evicted, evicted_value
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_data
);

    localparam int AW    = $clog2(ENTRIES);
    localparam int RW    = $clog2(ENTRIES);
    localparam int OW    = $clog2(ENTRIES + 1);
    localparam int CMPW  = ((OW > CAP_W) ? OW : CAP_W) + 2;
    localparam int WORD  = RW + VALUE_BITS + KEY_BITS;
    localparam logic [CMPW-1:0] CAP_MAX = CMPW'(ENTRIES + 1);
    localparam logic [AW:0]     ISS_END = (AW + 1)'(ENTRIES);
    localparam logic [AW-1:0]   LAST    = AW'(ENTRIES - 1);

    lkv_state_t state_reg, state_next;
    logic [CAP_W-1:0]      cap_reg;
    logic [ENTRIES-1:0]    valid_reg, valid_next;
    logic [OW-1:0]         occ_reg, occ_next;
    logic [CMD_W-1:0]      cmd_reg, cmd_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [AW:0]           iss_reg, iss_next;
    logic                  rv_reg, rv_next;
    logic [AW-1:0]         ridx_reg, ridx_next;
    // Scan results.
    logic                  fnd_reg, fnd_next;
    logic [AW-1:0]         s_idx_reg, s_idx_next;
    logic [RW-1:0]         s_rank_reg, s_rank_next;
    logic [VALUE_BITS-1:0] s_val_reg, s_val_next;
    logic                  lru_ok_reg, lru_ok_next;
    logic [AW-1:0]         lru_idx_reg, lru_idx_next;
    logic [RW-1:0]         lru_rank_reg, lru_rank_next;
    logic [VALUE_BITS-1:0] lru_val_reg, lru_val_next;
    logic                  free_ok_reg, free_ok_next;
    logic [AW-1:0]         free_idx_reg, free_idx_next;
    // Update mode.
    logic                  ins_reg, ins_next;
    logic                  wval_reg, wval_next;
    logic [AW-1:0]         slot_reg, slot_next;
    // Result.
    logic                  hit_reg, hit_next;
    logic [VALUE_BITS-1:0] fv_reg, fv_next;
    logic                  ev_reg, ev_next;
    logic [VALUE_BITS-1:0] evv_reg, evv_next;
    logic                  mv_reg, mv_next;
    logic [OUT_W-1:0]      md_reg, md_next;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [WORD-1:0]       ram_wdata;
    logic [WORD-1:0]       ram_rdata;
    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_val;
    logic [RW-1:0]         rd_rank;
    logic                  rd_valid;
    logic [CMPW-1:0]       cap_eff;
    logic [CMPW-1:0]       occ_inc;
    logic                  full;

    assign rd_key   = ram_rdata[KEY_BITS-1:0];
    assign rd_val   = ram_rdata[KEY_BITS +: VALUE_BITS];
    assign rd_rank  = ram_rdata[KEY_BITS + VALUE_BITS +: RW];
    assign rd_valid = valid_reg[ridx_reg];

    always_comb
    begin
        cap_eff = CMPW'(cap_reg);
        if (cap_eff == '0)
        begin
            cap_eff = CMPW'(1);
        end
        else if (cap_eff > CAP_MAX)
        begin
            cap_eff = CAP_MAX;
        end
    end

    assign occ_inc = CMPW'(occ_reg) + CMPW'(1);
    assign full    = (occ_inc >= cap_eff);

    lkv_ram #(
        .WIDTH (WORD),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (iss_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        valid_next    = valid_reg;
        occ_next      = occ_reg;
        cmd_next      = cmd_reg;
        key_next      = key_reg;
        val_next      = val_reg;
        iss_next      = iss_reg;
        rv_next       = 1'b0;
        ridx_next     = iss_reg[AW-1:0];
        fnd_next      = fnd_reg;
        s_idx_next    = s_idx_reg;
        s_rank_next   = s_rank_reg;
        s_val_next    = s_val_reg;
        lru_ok_next   = lru_ok_reg;
        lru_idx_next  = lru_idx_reg;
        lru_rank_next = lru_rank_reg;
        lru_val_next  = lru_val_reg;
        free_ok_next  = free_ok_reg;
        free_idx_next = free_idx_reg;
        ins_next      = ins_reg;
        wval_next     = wval_reg;
        slot_next     = slot_reg;
        hit_next      = hit_reg;
        fv_next       = fv_reg;
        ev_next       = ev_reg;
        evv_next      = evv_reg;
        mv_next       = mv_reg;
        md_next       = md_reg;
        ram_we        = 1'b0;
        ram_waddr     = ridx_reg;
        ram_wdata     = ram_rdata;
        s_tready      = 1'b0;

        if (mv_reg && m_tready)
        begin
            mv_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd_next     = s_tuser;
                    key_next     = s_tdata[KEY_BITS-1:0];
                    val_next     = s_tdata[KEY_BITS +: VALUE_BITS];
                    iss_next     = '0;
                    fnd_next     = 1'b0;
                    lru_ok_next  = 1'b0;
                    free_ok_next = 1'b0;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (iss_reg != ISS_END)
                begin
                    rv_next  = 1'b1;
                    iss_next = iss_reg + 1'b1;
                end
                if (rv_reg)
                begin
                    if (rd_valid && !fnd_reg && rd_key == key_reg)
                    begin
                        fnd_next    = 1'b1;
                        s_idx_next  = ridx_reg;
                        s_rank_next = rd_rank;
                        s_val_next  = rd_val;
                    end
                    if (rd_valid && (!lru_ok_reg || rd_rank > lru_rank_reg))
                    begin
                        lru_ok_next   = 1'b1;
                        lru_idx_next  = ridx_reg;
                        lru_rank_next = rd_rank;
                        lru_val_next  = rd_val;
                    end
                    if (!rd_valid && !free_ok_reg)
                    begin
                        free_ok_next  = 1'b1;
                        free_idx_next = ridx_reg;
                    end
                    if (ridx_reg == LAST)
                    begin
                        state_next = ST_DECIDE;
                    end
                end
            end
            ST_DECIDE:
            begin
                hit_next   = 1'b0;
                fv_next    = '0;
                ev_next    = 1'b0;
                evv_next   = '0;
                iss_next   = '0;
                ins_next   = 1'b0;
                wval_next  = 1'b0;
                state_next = ST_FINISH;
                case (cmd_reg)
                    CMD_LOOKUP:
                    begin
                        hit_next = fnd_reg;
                        if (fnd_reg)
                        begin
                            fv_next    = s_val_reg;
                            state_next = ST_UPDATE;
                        end
                    end
                    CMD_PROBE:
                    begin
                        hit_next = fnd_reg;
                    end
                    CMD_INSERT:
                    begin
                        hit_next = fnd_reg;
                        if (fnd_reg)
                        begin
                            wval_next  = 1'b1;
                            state_next = ST_UPDATE;
                        end
                        else if (full && occ_reg == '0)
                        begin
                            // The new entry is at once the least recent one.
                            ev_next  = 1'b1;
                            evv_next = val_reg;
                        end
                        else
                        begin
                            ins_next   = 1'b1;
                            state_next = ST_UPDATE;
                            if (full)
                            begin
                                ev_next                 = 1'b1;
                                evv_next                = lru_val_reg;
                                valid_next[lru_idx_reg] = 1'b0;
                                if (free_ok_reg && free_idx_reg < lru_idx_reg)
                                begin
                                    slot_next = free_idx_reg;
                                end
                                else
                                begin
                                    slot_next = lru_idx_reg;
                                end
                                valid_next[slot_next] = 1'b1;
                            end
                            else
                            begin
                                slot_next              = free_idx_reg;
                                valid_next[free_idx_reg] = 1'b1;
                                occ_next               = occ_reg + 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_UPDATE:
            begin
                if (iss_reg != ISS_END)
                begin
                    rv_next  = 1'b1;
                    iss_next = iss_reg + 1'b1;
                end
                if (rv_reg)
                begin
                    if (ins_reg)
                    begin
                        if (ridx_reg == slot_reg)
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = {RW'(0), val_reg, key_reg};
                        end
                        else if (rd_valid)
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = {rd_rank + 1'b1, rd_val, rd_key};
                        end
                    end
                    else
                    begin
                        if (ridx_reg == s_idx_reg)
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = {RW'(0), wval_reg ? val_reg : rd_val, rd_key};
                        end
                        else if (rd_valid && rd_rank < s_rank_reg)
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = {rd_rank + 1'b1, rd_val, rd_key};
                        end
                    end
                    if (ridx_reg == LAST)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                if (!mv_reg || m_tready)
                begin
                    mv_next    = 1'b1;
                    md_next    = OUT_W'({evv_reg, ev_reg, fv_reg, hit_reg});
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cap_reg   <= CAP_RESET;
            valid_reg <= '0;
            occ_reg   <= '0;
            rv_reg    <= 1'b0;
            mv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            occ_reg   <= occ_next;
            rv_reg    <= rv_next;
            mv_reg    <= mv_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        val_reg      <= val_next;
        iss_reg      <= iss_next;
        ridx_reg     <= ridx_next;
        fnd_reg      <= fnd_next;
        s_idx_reg    <= s_idx_next;
        s_rank_reg   <= s_rank_next;
        s_val_reg    <= s_val_next;
        lru_ok_reg   <= lru_ok_next;
        lru_idx_reg  <= lru_idx_next;
        lru_rank_reg <= lru_rank_next;
        lru_val_reg  <= lru_val_next;
        free_ok_reg  <= free_ok_next;
        free_idx_reg <= free_idx_next;
        ins_reg      <= ins_next;
        wval_reg     <= wval_next;
        slot_reg     <= slot_next;
        hit_reg      <= hit_next;
        fv_reg       <= fv_next;
        ev_reg       <= ev_next;
        evv_reg      <= evv_next;
        md_reg       <= md_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;

    // The occupancy count always matches the number of valid entries between commands.
    a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> $countones(valid_reg) == 32'(occ_reg))
        else $error("occupancy does not match valid entries");

    // The occupancy never exceeds the number of entries.
    a_occ_max: assert property (@(posedge clk) disable iff (!rst_n)
        32'(occ_reg) <= ENTRIES)
        else $error("occupancy above entry count");

    // A write-back never hits the entry that is being read in the same cycle.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && iss_reg != ISS_END) |-> ram_waddr != iss_reg[AW-1:0])
        else $error("read-modify-write overlap on one entry");

    // A command accepted from idle never leaves its result unissued past a finish.
    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && (!mv_reg || m_tready)) |=> mv_reg)
        else $error("result not issued at finish");

endmodule
